// ===== rtl/core/hps_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the heatmap peak suppression core
package hps_pkg;

	localparam int POS_W   = 7;
	localparam int SCORE_W = 16;
	localparam int COUNT_W = 11;

	localparam logic [SCORE_W-1:0] THRESH_RESET = 16'd13107;
	localparam int NEAR_ROWS = 2;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_RUN   = 2'd1,
		REQ_READ  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_SCAN,
		ST_DRAIN,
		ST_I_CHECK,
		ST_I_LOAD,
		ST_I_SCORE,
		ST_J_CHECK,
		ST_J_LOAD,
		ST_J_TEST,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic accept;
		logic do_write;
		logic do_read;
		logic scan_step;
		logic cand_rd_i;
		logic cand_rd_j;
		logic i_load;
		logic i_score;
		logic j_load;
		logic pair_step;
		logic i_next;
		logic respond;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic i_done;
		logic j_done;
		logic brk;
	} status_t;

endpackage

// ===== rtl/core/hps_ram.sv =====
`timescale 1ns / 1ps
// generic simple dual port ram with registered read
module hps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/hps_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine for the heatmap peak suppression core
module hps_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  hps_pkg::req_t    req_type,
	input  hps_pkg::status_t status,
	output logic             busy,
	output hps_pkg::cmd_t    cmd
);
	import hps_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (req_type)
						REQ_WRITE: state_nx = ST_WRITE;
						REQ_READ:  state_nx = ST_READ;
						REQ_RUN:   state_nx = ST_SCAN;
						default:   state_nx = ST_RESP;
					endcase
				end
			end
			ST_WRITE:   state_nx = ST_RESP;
			ST_READ:    state_nx = ST_RESP;
			ST_SCAN: begin
				if (status.scan_last) state_nx = ST_DRAIN;
			end
			ST_DRAIN:   state_nx = ST_I_CHECK;
			ST_I_CHECK: state_nx = status.i_done ? ST_RESP : ST_I_LOAD;
			ST_I_LOAD:  state_nx = ST_I_SCORE;
			ST_I_SCORE: state_nx = ST_J_CHECK;
			ST_J_CHECK: state_nx = status.j_done ? ST_I_CHECK : ST_J_LOAD;
			ST_J_LOAD:  state_nx = ST_J_TEST;
			ST_J_TEST:  state_nx = status.brk ? ST_I_CHECK : ST_J_CHECK;
			ST_RESP:    state_nx = ST_IDLE;
			default:    state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy       = 1'b0;
				cmd.accept = start;
			end
			ST_WRITE:   cmd.do_write  = 1'b1;
			ST_READ:    cmd.do_read   = 1'b1;
			ST_SCAN:    cmd.scan_step = 1'b1;
			ST_DRAIN:   ;
			ST_I_CHECK: cmd.cand_rd_i = !status.i_done;
			ST_I_LOAD:  cmd.i_load    = 1'b1;
			ST_I_SCORE: cmd.i_score   = 1'b1;
			ST_J_CHECK: begin
				cmd.cand_rd_j = !status.j_done;
				cmd.i_next    = status.j_done;
			end
			ST_J_LOAD:  cmd.j_load    = 1'b1;
			ST_J_TEST: begin
				cmd.i_next    = status.brk;
				cmd.pair_step = !status.brk;
			end
			ST_RESP:    cmd.respond   = 1'b1;
			default:    ;
		endcase
	end

endmodule

// ===== rtl/core/hps_datapath.sv =====
`timescale 1ns / 1ps
// datapath: score map, candidate list, pair test and result registers
module hps_datapath #(
	parameter int MAP_WIDTH  = 128,
	parameter int MAP_HEIGHT = 128,
	parameter int MAX_POINTS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hps_pkg::cmd_t                 cmd,
	output hps_pkg::status_t              status,
	input  hps_pkg::req_t                 req_type,
	input  logic [hps_pkg::POS_W-1:0]     pos_x,
	input  logic [hps_pkg::POS_W-1:0]     pos_y,
	input  logic [hps_pkg::SCORE_W-1:0]   score_in,
	input  logic                          cfg_wr_en,
	input  logic [hps_pkg::SCORE_W-1:0]   cfg_wr_data,
	output logic                          done,
	output logic [1:0]                    resp_kind,
	output logic [hps_pkg::SCORE_W-1:0]   score_out,
	output logic [hps_pkg::COUNT_W-1:0]   candidate_count,
	output logic                          overflow
);
	import hps_pkg::*;

	localparam int XW     = $clog2(MAP_WIDTH);
	localparam int YW     = $clog2(MAP_HEIGHT);
	localparam int CELL_W = XW + YW;
	localparam int PW     = $clog2(MAX_POINTS);
	localparam int CW     = $clog2(MAX_POINTS + 1);

	req_t               req_q;
	logic [POS_W-1:0]   x_q;
	logic [POS_W-1:0]   y_q;
	logic [SCORE_W-1:0] score_q;
	logic               in_map_q;
	logic [SCORE_W-1:0] thr_q;

	logic [XW-1:0]      sx_q;
	logic [YW-1:0]      sy_q;
	logic               valid_s1;
	logic [CELL_W-1:0]  cell_s1;
	logic [CW-1:0]      n_q;
	logic               ovf_q;

	logic [CW-1:0]      i_q;
	logic [CW-1:0]      j_q;
	logic [XW-1:0]      xi_q;
	logic [YW-1:0]      yi_q;
	logic [XW-1:0]      xj_q;
	logic [YW-1:0]      yj_q;
	logic [SCORE_W-1:0] si_q;

	logic               done_q;
	req_t               resp_kind_q;
	logic [SCORE_W-1:0] score_out_q;
	logic [COUNT_W-1:0] count_q;
	logic               overflow_q;

	logic               h_we;
	logic [CELL_W-1:0]  h_waddr;
	logic [SCORE_W-1:0] h_wdata;
	logic               h_re;
	logic [CELL_W-1:0]  h_raddr;
	logic [SCORE_W-1:0] h_rdata;

	logic               c_we;
	logic [PW-1:0]      c_waddr;
	logic               c_re;
	logic [PW-1:0]      c_raddr;
	logic [CELL_W-1:0]  c_rdata;

	logic [CELL_W-1:0]  req_cell;
	logic [XW-1:0]      dx;
	logic [YW-1:0]      dy;
	logic               near;
	logic               pi_keep;
	logic               hit_s1;
	logic               room;

	assign req_cell = {YW'(y_q), XW'(x_q)};
	assign dx       = (xi_q > xj_q) ? (xi_q - xj_q) : (xj_q - xi_q);
	assign dy       = (yi_q > yj_q) ? (yi_q - yj_q) : (yj_q - yi_q);
	assign near     = ((dy == '0) && (dx <= XW'(2))) ||
	                  ((dx == '0) && (dy <= YW'(2))) ||
	                  ((dx == XW'(1)) && (dy == YW'(1)));
	assign pi_keep  = si_q > h_rdata;
	assign hit_s1   = valid_s1 && (h_rdata > thr_q);
	assign room     = n_q < CW'(MAX_POINTS);

	assign status.scan_last = (sx_q == XW'(MAP_WIDTH - 1)) && (sy_q == YW'(MAP_HEIGHT - 1));
	assign status.i_done    = i_q >= n_q;
	assign status.j_done    = j_q >= n_q;
	assign status.brk       = {1'b0, yj_q} > ({1'b0, yi_q} + (YW + 1)'(NEAR_ROWS));

	always_comb begin
		h_re = cmd.do_read | cmd.scan_step | cmd.i_load | cmd.j_load;
		if (cmd.scan_step) begin
			h_raddr = {sy_q, sx_q};
		end else if (cmd.i_load || cmd.j_load) begin
			h_raddr = c_rdata;
		end else begin
			h_raddr = req_cell;
		end
		h_we = (cmd.do_write && in_map_q) || (cmd.pair_step && near);
		if (cmd.pair_step) begin
			h_waddr = pi_keep ? {yj_q, xj_q} : {yi_q, xi_q};
			h_wdata = '0;
		end else begin
			h_waddr = req_cell;
			h_wdata = score_q;
		end
	end

	assign c_we    = hit_s1 && room;
	assign c_waddr = n_q[PW-1:0];
	assign c_re    = cmd.cand_rd_i | cmd.cand_rd_j;
	assign c_raddr = cmd.cand_rd_j ? j_q[PW-1:0] : i_q[PW-1:0];

	hps_ram #(
		.WIDTH(SCORE_W),
		.DEPTH(1 << CELL_W)
	) u_heat_ram (
		.clk  (clk),
		.we   (h_we),
		.waddr(h_waddr),
		.wdata(h_wdata),
		.re   (h_re),
		.raddr(h_raddr),
		.rdata(h_rdata)
	);

	hps_ram #(
		.WIDTH(CELL_W),
		.DEPTH(MAX_POINTS)
	) u_cand_ram (
		.clk  (clk),
		.we   (c_we),
		.waddr(c_waddr),
		.wdata(cell_s1),
		.re   (c_re),
		.raddr(c_raddr),
		.rdata(c_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THRESH_RESET;
			valid_s1 <= 1'b0;
			n_q      <= '0;
			ovf_q    <= 1'b0;
			done_q   <= 1'b0;
			sx_q     <= '0;
			sy_q     <= '0;
			i_q      <= '0;
			j_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			valid_s1 <= cmd.scan_step;
			done_q   <= cmd.respond;
			if (cmd.accept && (req_type == REQ_RUN)) begin
				n_q   <= '0;
				ovf_q <= 1'b0;
				sx_q  <= '0;
				sy_q  <= '0;
				i_q   <= '0;
			end else begin
				if (hit_s1) begin
					if (room) begin
						n_q <= n_q + CW'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end
				if (cmd.scan_step) begin
					if (sx_q == XW'(MAP_WIDTH - 1)) begin
						sx_q <= '0;
						sy_q <= sy_q + YW'(1);
					end else begin
						sx_q <= sx_q + XW'(1);
					end
				end
				if (cmd.i_next) begin
					i_q <= i_q + CW'(1);
				end
			end
			if (cmd.i_load) begin
				j_q <= i_q + CW'(1);
			end else if (cmd.pair_step) begin
				j_q <= j_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q    <= req_type;
			x_q      <= pos_x;
			y_q      <= pos_y;
			score_q  <= score_in;
			in_map_q <= (32'(pos_x) < MAP_WIDTH) && (32'(pos_y) < MAP_HEIGHT);
		end
		cell_s1 <= {sy_q, sx_q};
		if (cmd.i_load) begin
			{yi_q, xi_q} <= c_rdata;
		end
		if (cmd.j_load) begin
			{yj_q, xj_q} <= c_rdata;
		end
		if (cmd.i_score) begin
			si_q <= h_rdata;
		end else if (cmd.pair_step && near && !pi_keep) begin
			si_q <= '0;
		end
		if (cmd.respond) begin
			resp_kind_q <= req_q;
			score_out_q <= ((req_q == REQ_READ) && in_map_q) ? h_rdata : '0;
			count_q     <= (req_q == REQ_RUN) ? COUNT_W'(n_q) : '0;
			overflow_q  <= (req_q == REQ_RUN) && ovf_q;
		end
	end

	assign done            = done_q;
	assign resp_kind       = resp_kind_q;
	assign score_out       = score_out_q;
	assign candidate_count = count_q;
	assign overflow        = overflow_q;

endmodule

// ===== rtl/core/heatmap_peak_suppression_core.sv =====
`timescale 1ns / 1ps
// top level of the heatmap peak suppression core
// write and read items go through their write or read state, then the response state;
//   unknown items go straight to the response state, which registers done; the next item
//   may start in the done cycle. run item: one map read per pixel in the scan, then one
//   map read per pair test step over the n candidates
// the receiver cannot stall; arst_n clears control, the internal count and overflow, threshold to 13107
module heatmap_peak_suppression_core #(
	parameter int MAP_WIDTH  = 128,
	parameter int MAP_HEIGHT = 128,
	parameter int MAX_POINTS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  req_type,
	input  logic [hps_pkg::POS_W-1:0]   pos_x,
	input  logic [hps_pkg::POS_W-1:0]   pos_y,
	input  logic [hps_pkg::SCORE_W-1:0] score_in,
	input  logic                        cfg_wr_en,
	input  logic [hps_pkg::SCORE_W-1:0] cfg_wr_data,
	output logic                        done,
	output logic [1:0]                  resp_kind,
	output logic [hps_pkg::SCORE_W-1:0] score_out,
	output logic [hps_pkg::COUNT_W-1:0] candidate_count,
	output logic                        overflow
);
	import hps_pkg::*;

	cmd_t    cmd;
	status_t status;
	req_t    req;

	assign req = req_t'(req_type);

	hps_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req_type(req),
		.status  (status),
		.busy    (busy),
		.cmd     (cmd)
	);

	hps_datapath #(
		.MAP_WIDTH (MAP_WIDTH),
		.MAP_HEIGHT(MAP_HEIGHT),
		.MAX_POINTS(MAX_POINTS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.req_type       (req),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.score_in       (score_in),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.done           (done),
		.resp_kind      (resp_kind),
		.score_out      (score_out),
		.candidate_count(candidate_count),
		.overflow       (overflow)
	);

endmodule

// ===== rtl/core/hps_checker.sv =====
`timescale 1ns / 1ps
// port level checks for the heatmap peak suppression core, with bind
module hps_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [1:0]                  resp_kind,
	input logic [hps_pkg::SCORE_W-1:0] score_out,
	input logic [hps_pkg::COUNT_W-1:0] candidate_count,
	input logic                        overflow
);
	import hps_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done strobe while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done strobe longer than one cycle");

	a_score_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (resp_kind != REQ_READ)) |-> (score_out == '0))
		else $error("score on a non-read item");

	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (resp_kind != REQ_RUN)) |-> ((candidate_count == '0) && !overflow))
		else $error("count or overflow on a non-run item");

endmodule

bind heatmap_peak_suppression_core hps_checker u_hps_checker (.*);
